// ===== rtl/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types, error codes and character constants for the quoted string
// unescaper.
// ----------------------------------------------------------------------------
package qsu_pkg;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_OPENER   = 3'd2,
    ERR_MISMATCH = 3'd3,
    ERR_ESCAPE   = 3'd4,
    ERR_TRAILING = 3'd5
  } err_t;

  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_LC_A     = 8'h61;
  localparam logic [7:0] CH_LC_B     = 8'h62;
  localparam logic [7:0] CH_LC_F     = 8'h66;
  localparam logic [7:0] CH_LC_N     = 8'h6E;
  localparam logic [7:0] CH_LC_R     = 8'h72;
  localparam logic [7:0] CH_LC_T     = 8'h74;
  localparam logic [7:0] CH_LC_V     = 8'h76;
  localparam logic [7:0] CTL_BEL     = 8'h07;
  localparam logic [7:0] CTL_BS      = 8'h08;
  localparam logic [7:0] CTL_HT      = 8'h09;
  localparam logic [7:0] CTL_LF      = 8'h0A;
  localparam logic [7:0] CTL_VT      = 8'h0B;
  localparam logic [7:0] CTL_FF      = 8'h0C;
  localparam logic [7:0] CTL_CR      = 8'h0D;
  localparam logic [7:0] CTL_NUL     = 8'h00;

  typedef struct packed {
    logic       inside_literal;
    logic       opener_is_single;
    logic [7:0] held_byte;
    logic       held_valid;
    logic       escape_pending;
    err_t       sticky_error;
  } state_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] decoded_char;
    logic       string_done;
    err_t       error_code;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  localparam state_t STATE_RESET = '{
    inside_literal:   1'b0,
    opener_is_single: 1'b0,
    held_byte:        8'h00,
    held_valid:       1'b0,
    escape_pending:   1'b0,
    sticky_error:     ERR_NONE
  };

  function automatic esc_t map_escape(input logic [7:0] b);
    esc_t r;
    r.ok = 1'b1;
    r.ch = CTL_NUL;
    case (b)
      CH_BSLASH: r.ch = CH_BSLASH;
      CH_SQUOTE: r.ch = CH_SQUOTE;
      CH_DQUOTE: r.ch = CH_DQUOTE;
      CH_LC_A:   r.ch = CTL_BEL;
      CH_LC_B:   r.ch = CTL_BS;
      CH_LC_F:   r.ch = CTL_FF;
      CH_LC_N:   r.ch = CTL_LF;
      CH_LC_R:   r.ch = CTL_CR;
      CH_LC_T:   r.ch = CTL_HT;
      CH_LC_V:   r.ch = CTL_VT;
      CH_QMARK:  r.ch = CH_QMARK;
      CH_ZERO:   r.ch = CTL_NUL;
      default:   r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/qsu_ifs.sv =====
// ----------------------------------------------------------------------------
// qsu channel interfaces
// Valid/ready channels for raw input bytes and decoded results.
// ----------------------------------------------------------------------------
interface qsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface qsu_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] decoded_char;
  logic       string_done;
  logic [2:0] error_code;

  modport source (output valid, output char_valid, output decoded_char,
                  output string_done, output error_code, input ready);
  modport sink   (input valid, input char_valid, input decoded_char,
                  input string_done, input error_code, output ready);
endinterface

// ===== rtl/qsu_decode.sv =====
// ----------------------------------------------------------------------------
// qsu_decode
// Per-byte decode step: next state and result for one raw byte.
// ----------------------------------------------------------------------------
module qsu_decode (
  input  qsu_pkg::state_t  cur,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output qsu_pkg::state_t  nxt,
  output qsu_pkg::result_t res
);
  import qsu_pkg::*;

  logic [7:0] opener;
  logic       is_quote;
  esc_t       esc;
  logic       made;
  logic [7:0] c;

  always_comb begin
    opener   = cur.opener_is_single ? CH_SQUOTE : CH_DQUOTE;
    is_quote = (in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE);
    esc      = map_escape(in_byte);
    made     = 1'b0;
    c        = CTL_NUL;
    nxt      = cur;
    res      = '0;

    if (!cur.inside_literal) begin
      nxt = STATE_RESET;
      if (in_last) begin
        res.string_done = 1'b1;
        res.error_code  = ERR_SHORT;
      end else begin
        nxt.inside_literal = 1'b1;
        if (is_quote) begin
          nxt.opener_is_single = (in_byte == CH_SQUOTE);
        end else begin
          nxt.sticky_error = ERR_OPENER;
        end
      end
    end else if (in_last) begin
      res.char_valid   = cur.held_valid;
      res.decoded_char = cur.held_valid ? cur.held_byte : CTL_NUL;
      res.string_done  = 1'b1;
      if (cur.sticky_error == ERR_OPENER) begin
        res.error_code = ERR_OPENER;
      end else if (in_byte != opener) begin
        res.error_code = ERR_MISMATCH;
      end else if (cur.sticky_error != ERR_NONE) begin
        res.error_code = cur.sticky_error;
      end else if (cur.escape_pending) begin
        res.error_code = ERR_TRAILING;
      end else begin
        res.error_code = ERR_NONE;
      end
      nxt = STATE_RESET;
    end else begin
      if (cur.escape_pending) begin
        nxt.escape_pending = 1'b0;
        if (esc.ok) begin
          made = 1'b1;
          c    = esc.ch;
        end else if (cur.sticky_error == ERR_NONE) begin
          nxt.sticky_error = ERR_ESCAPE;
        end
      end else if (in_byte == CH_BSLASH) begin
        nxt.escape_pending = 1'b1;
      end else begin
        made = 1'b1;
        c    = in_byte;
      end
      res.char_valid   = cur.held_valid;
      res.decoded_char = cur.held_valid ? cur.held_byte : CTL_NUL;
      nxt.held_valid   = made;
      nxt.held_byte    = made ? c : CTL_NUL;
    end
  end

endmodule

// ===== rtl/quoted_string_unescaper_top.sv =====
// ----------------------------------------------------------------------------
// quoted_string_unescaper_top
// Decodes a quoted C-style literal, one raw byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : raw bytes of the literal, in_last set on the closing byte.
//   out_ch : exactly one result transaction per input transaction. A result
//            carries the previous decoded character (char_valid), and on the
//            final byte string_done plus error_code. Characters of a literal
//            that ends with a nonzero error_code are to be dropped.
//   Result: each result is registered and appears in the cycle after its byte.
//   Throughput: one byte per cycle unless out_ch stalls; decode is a single
//            combinational step between the state and result registers.
//   Stall: the result register holds while out_ch.ready is low; in_ch.ready
//            is high whenever that register is empty or being drained.
//   Reset: rst_n (synchronous, active low) empties the result register and
//            returns the decoder to waiting for an opening quote.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_top (
  input  logic             clk,
  input  logic             rst_n,
  qsu_in_if.sink           in_ch,
  qsu_out_if.source        out_ch
);
  import qsu_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    in_acc;

  qsu_decode u_decode (
    .cur     (state_r),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_valid_nxt = in_acc || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.char_valid   = res_r.char_valid;
  assign out_ch.decoded_char = res_r.decoded_char;
  assign out_ch.string_done  = res_r.string_done;
  assign out_ch.error_code   = res_r.error_code;

`ifndef SYNTHESIS
  a_err_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.string_done) |-> (out_ch.error_code == ERR_NONE))
    else $error("error code on a non-final result");

  a_nochar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.char_valid) |-> (out_ch.decoded_char == CTL_NUL))
    else $error("decoded_char nonzero without char_valid");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.in_last) |=> (!state_r.inside_literal && out_ch.string_done))
    else $error("final byte did not close the literal");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_ch.valid)
    else $error("accepted transaction produced no result");
`endif

endmodule
